### src/memory_region_atomic_unit_defines.svh
// Assertion macros shared by the memory region atomic unit.
`ifndef MEMORY_REGION_ATOMIC_UNIT_DEFINES_SVH
`define MEMORY_REGION_ATOMIC_UNIT_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define MRAU_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define MRAU_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### src/mrau_pkg.sv
// Types, codes and helper functions of the memory region atomic unit.
`timescale 1ns / 1ps
`default_nettype none
package mrau_pkg;

  localparam int unsigned SIZE_W    = 17;
  localparam int unsigned CFG_IDX_W = 1;

  localparam logic [CFG_IDX_W-1:0] CFG_REGION_BASE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_REGION_SIZE = 1'b1;

  typedef enum logic [3:0] {
    CMD_READ  = 4'd0,
    CMD_WRITE = 4'd1,
    CMD_SWAP  = 4'd2,
    CMD_ADD   = 4'd3,
    CMD_AND   = 4'd4,
    CMD_OR    = 4'd5,
    CMD_XOR   = 4'd6,
    CMD_MIN   = 4'd7,
    CMD_MAX   = 4'd8,
    CMD_MINU  = 4'd9,
    CMD_MAXU  = 4'd10,
    CMD_CAS   = 4'd11
  } cmd_t;

  typedef enum logic {
    ST_IDLE,
    ST_MOD
  } state_t;

  typedef struct packed {
    logic [3:0]  command;
    logic [63:0] address;
    logic [63:0] operand;
    logic [63:0] expected;
    logic [1:0]  size_log2;
  } in_word_t;

  typedef struct packed {
    logic [63:0] read_data;
    logic        hit;
    logic        cas_success;
  } out_word_t;

  typedef struct packed {
    logic        wr;
    logic        cas_ok;
    logic [63:0] rdata;
    logic [63:0] nv;
  } alu_res_t;

  function automatic logic [63:0] width_mask(input logic [1:0] size_log2);
    logic [63:0] m;
    unique case (size_log2)
      2'd0:    m = 64'h0000_0000_0000_00FF;
      2'd1:    m = 64'h0000_0000_0000_FFFF;
      2'd2:    m = 64'h0000_0000_FFFF_FFFF;
      default: m = 64'hFFFF_FFFF_FFFF_FFFF;
    endcase
    return m;
  endfunction

  function automatic logic [63:0] sign_ext(input logic [63:0] v, input logic [1:0] size_log2);
    logic [63:0] s;
    unique case (size_log2)
      2'd0:    s = {{56{v[7]}}, v[7:0]};
      2'd1:    s = {{48{v[15]}}, v[15:0]};
      2'd2:    s = {{32{v[31]}}, v[31:0]};
      default: s = v;
    endcase
    return s;
  endfunction

endpackage
`default_nettype wire

### src/mrau_in_if.sv
// Request channel carrying one access word from source to sink.
`timescale 1ns / 1ps
`default_nettype none
interface mrau_in_if;
  import mrau_pkg::*;

  logic     valid;
  logic     ready;
  in_word_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

### src/mrau_out_if.sv
// Result channel carrying one response word from source to sink.
`timescale 1ns / 1ps
`default_nettype none
interface mrau_out_if;
  import mrau_pkg::*;

  logic      valid;
  logic      ready;
  out_word_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

### src/mrau_lane_ram.sv
// One byte lane of the region store: synchronous RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none
module mrau_lane_ram #(
  parameter int unsigned DEPTH = 8192,
  parameter int unsigned AW    = 13
) (
  input  wire logic          clk,
  input  wire logic          re,
  input  wire logic [AW-1:0] raddr,
  output logic      [7:0]    rdata,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire logic [7:0]    wdata
);

  logic [7:0] mem [DEPTH];
  logic [7:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule
`default_nettype wire

### src/mrau_alu.sv
// Read-modify-write datapath: new value, returned value and store decision.
`timescale 1ns / 1ps
`default_nettype none
module mrau_alu (
  input  wire logic [3:0]          command,
  input  wire logic [1:0]          size_log2,
  input  wire logic [63:0]         old_val,
  input  wire logic [63:0]         operand,
  input  wire logic [63:0]         expected,
  output mrau_pkg::alu_res_t       res
);
  import mrau_pkg::*;

  logic [63:0] mask;
  logic [63:0] a;
  logic [63:0] b;
  logic [63:0] e;
  logic [63:0] sa;
  logic [63:0] sb;
  logic        s_lt;
  logic        s_gt;

  assign mask = width_mask(size_log2);
  assign a    = old_val & mask;
  assign b    = operand & mask;
  assign e    = expected & mask;
  assign sa   = sign_ext(a, size_log2);
  assign sb   = sign_ext(b, size_log2);
  assign s_lt = $signed(sb) < $signed(sa);
  assign s_gt = $signed(sb) > $signed(sa);

  always_comb begin
    res.wr     = 1'b1;
    res.cas_ok = 1'b0;
    res.rdata  = a;
    res.nv     = b;
    unique case (cmd_t'(command))
      CMD_READ: begin
        res.wr = 1'b0;
      end
      CMD_WRITE: begin
        res.rdata = '0;
      end
      CMD_SWAP: begin
        res.nv = b;
      end
      CMD_ADD: begin
        res.nv = a + b;
      end
      CMD_AND: begin
        res.nv = a & b;
      end
      CMD_OR: begin
        res.nv = a | b;
      end
      CMD_XOR: begin
        res.nv = a ^ b;
      end
      CMD_MIN: begin
        res.nv    = s_lt ? b : a;
        res.rdata = sa;
      end
      CMD_MAX: begin
        res.nv    = s_gt ? b : a;
        res.rdata = sa;
      end
      CMD_MINU: begin
        res.nv = (b < a) ? b : a;
      end
      CMD_MAXU: begin
        res.nv = (b > a) ? b : a;
      end
      CMD_CAS: begin
        res.cas_ok = (a == e);
        res.wr     = (a == e);
      end
      default: begin
        res.wr    = 1'b0;
        res.rdata = '0;
      end
    endcase
  end

endmodule
`default_nettype wire

### src/memory_region_atomic_unit.sv
// Top level of the memory region atomic unit: range check, lane RAMs and control.
//
// Usage:
//   in_ch carries one access word (command, address, operand, expected,
//   size_log2); out_ch returns one word per access (read_data, hit,
//   cas_success) in order. Both use valid/ready; a word moves when both
//   are high. cfg_we writes region_base (index 0) or region_size (index 1)
//   from cfg_wdata; write them only while the unit is idle.
//   The store is eight byte-wide RAM lanes, so any 1, 2, 4 or 8 byte access
//   at any alignment needs one read of each lane at the accept edge and one
//   write-back in the modify state.
//   Results are registered: an accepted word passes the modify state and
//   its result is written to the output register.
//   The unit accepts no new request while an access is in the modify
//   state; each access makes one read and one write-back on the lane RAMs.
//   Reset: region_base returns to 0 and region_size to the full store (at most
//   65536 bytes); the store contents are not cleared and are undefined until written.
//   Stall: a result is held in the output register until taken; a new
//   request is accepted only once that register will be free.
`timescale 1ns / 1ps
`default_nettype none
`include "memory_region_atomic_unit_defines.svh"
module memory_region_atomic_unit #(
  parameter int unsigned STORE_BYTES = 65536
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  mrau_in_if.sink                              in_ch,
  mrau_out_if.source                           out_ch,
  input  wire logic                            cfg_we,
  input  wire logic [mrau_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [63:0]                     cfg_wdata
);
  import mrau_pkg::*;

  localparam int unsigned ROWS  = (STORE_BYTES + 7) / 8;
  localparam int unsigned ROW_W = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam logic [SIZE_W-1:0] SIZE_RST =
    (STORE_BYTES < 65536) ? SIZE_W'(STORE_BYTES) : SIZE_W'(65536);

  state_t            state_r;
  state_t            state_nxt;
  logic              in_ready;
  logic              mod_en;
  logic              accept;

  logic [63:0]       base_r;
  logic [SIZE_W-1:0] size_r;

  logic [63:0]       off_full;
  logic [3:0]        bytes_c;
  logic [SIZE_W:0]   end_c;
  logic              hit_c;
  logic [2:0]        off0;
  logic [ROW_W-1:0]  row0;
  logic [7:0]        inv_c;
  logic [ROW_W-1:0]  row_c [8];

  logic [3:0]        cmd_r;
  logic [63:0]       operand_r;
  logic [63:0]       expected_r;
  logic [1:0]        size_log2_r;
  logic              hit_r;
  logic [2:0]        off0_r;
  logic [7:0]        inv_r;
  logic [ROW_W-1:0]  row_r [8];

  logic [7:0]        lane_rd [8];
  logic [7:0]        lane_we;
  logic [63:0]       lane_q;
  logic [127:0]      rot_rd;
  logic [127:0]      rot_wr;
  logic [63:0]       old_val;
  logic [63:0]       wr_vec;
  alu_res_t          res;

  logic              out_valid_r;
  logic              out_valid_nxt;
  out_word_t         out_word_r;

  assign accept = in_ch.valid && in_ready;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          state_nxt = ST_MOD;
        end
      end
      ST_MOD: begin
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    in_ready = (state_r == ST_IDLE) && (!out_valid_r || out_ch.ready);
    mod_en   = (state_r == ST_MOD);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r <= '0;
      size_r <= SIZE_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_REGION_BASE: begin
          base_r <= cfg_wdata;
        end
        CFG_REGION_SIZE: begin
          if (32'(cfg_wdata[SIZE_W-1:0]) > 32'(STORE_BYTES)) begin
            size_r <= SIZE_W'(STORE_BYTES);
          end else begin
            size_r <= cfg_wdata[SIZE_W-1:0];
          end
        end
        default: begin
          base_r <= base_r;
        end
      endcase
    end
  end

  assign off_full = in_ch.data.address - base_r;
  assign bytes_c  = 4'b0001 << in_ch.data.size_log2;
  assign end_c    = {1'b0, off_full[SIZE_W-1:0]} + (SIZE_W + 1)'(bytes_c);
  assign hit_c    = (in_ch.data.address >= base_r) && (off_full[63:SIZE_W] == '0) &&
                    (end_c <= {1'b0, size_r});
  assign off0     = off_full[2:0];
  assign row0     = off_full[3 +: ROW_W];

  assign lane_q  = {lane_rd[7], lane_rd[6], lane_rd[5], lane_rd[4],
                    lane_rd[3], lane_rd[2], lane_rd[1], lane_rd[0]};
  assign rot_rd  = {lane_q, lane_q} >> {off0_r, 3'b000};
  assign old_val = rot_rd[63:0];

  mrau_alu u_alu (
    .command   (cmd_r),
    .size_log2 (size_log2_r),
    .old_val   (old_val),
    .operand   (operand_r),
    .expected  (expected_r),
    .res       (res)
  );

  assign rot_wr = {res.nv, res.nv} << {off0_r, 3'b000};
  assign wr_vec = rot_wr[127:64];

  for (genvar l = 0; l < 8; l++) begin : g_lane
    logic [2:0] rel;

    assign rel      = 3'(l) - off0;
    assign inv_c[l] = ({1'b0, rel} < bytes_c);
    assign row_c[l] = ((3'(l) < off0) && inv_c[l]) ? row0 + ROW_W'(1) : row0;
    assign lane_we[l] = mod_en && hit_r && res.wr && inv_r[l];

    mrau_lane_ram #(
      .DEPTH (ROWS),
      .AW    (ROW_W)
    ) u_ram (
      .clk   (clk),
      .re    (accept),
      .raddr (row_c[l]),
      .rdata (lane_rd[l]),
      .we    (lane_we[l]),
      .waddr (row_r[l]),
      .wdata (wr_vec[8*l +: 8])
    );
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_r       <= in_ch.data.command;
      operand_r   <= in_ch.data.operand;
      expected_r  <= in_ch.data.expected;
      size_log2_r <= in_ch.data.size_log2;
      hit_r       <= hit_c;
      off0_r      <= off0;
      inv_r       <= inv_c;
      for (int l = 0; l < 8; l++) begin
        row_r[l] <= row_c[l];
      end
    end
  end

  assign out_valid_nxt = mod_en || (out_valid_r && !out_ch.ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (mod_en) begin
      out_word_r.read_data   <= hit_r ? res.rdata : 64'd0;
      out_word_r.hit         <= hit_r;
      out_word_r.cas_success <= hit_r && res.cas_ok;
    end
  end

  assign in_ch.ready = in_ready;
  assign out_ch.valid = out_valid_r;
  assign out_ch.data  = out_word_r;

  `MRAU_ASSERT_NEXT(a_accept_to_mod, accept, state_r == ST_MOD,
                    "accepted word did not start a modify cycle")
  `MRAU_ASSERT_NEXT(a_mod_to_result, mod_en, out_valid_r,
                    "modify cycle did not produce a result")
  `MRAU_ASSERT_SAME(a_write_on_hit, lane_we != 8'd0, mod_en && hit_r,
                    "store written outside a hitting modify cycle")
  `MRAU_ASSERT_SAME(a_cas_needs_hit, out_valid_r && out_word_r.cas_success, out_word_r.hit,
                    "compare-and-swap success reported on a miss")

endmodule
`default_nettype wire

### dv/tb_top.sv
// Self-checking testbench of the memory region atomic unit with a shadow store of its bytes.
`timescale 1ns / 1ps
module tb_top;
  import mrau_pkg::*;

  localparam int unsigned STORE_BYTES = 65536;
  localparam int unsigned CYCLE_LIMIT = 300000;
  localparam int unsigned MAX_REPORTS = 100;
  localparam logic [3:0] CMD_SPARE_FIRST = 4'd12;
  localparam logic [3:0] CMD_SPARE_LAST = 4'd15;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [63:0] cfg_wdata;

  mrau_in_if in_ch ();
  mrau_out_if out_ch ();

  memory_region_atomic_unit #(.STORE_BYTES(STORE_BYTES)) i_dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_ch(in_ch),
    .out_ch(out_ch),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  // Shadow of the store as the unit sees it, and the bytes that requests have written so far.
  logic [7:0] mem_shadow [STORE_BYTES];
  bit byte_written [STORE_BYTES];
  logic [63:0] region_base_q;
  logic [SIZE_W-1:0] region_size_q;

  in_word_t pending_words[$];
  out_word_t awaited_results[$];

  bit send_steady;
  bit recv_steady;
  int unsigned send_wait;
  int unsigned recv_wait;
  int unsigned recv_hold;
  int unsigned cycle_count;
  int unsigned errors;
  int unsigned accepted_words;
  int unsigned checked_results;
  int unsigned hit_results;
  int unsigned cas_wins;
  int unsigned reg_writes;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [63:0] size_mask(input logic [1:0] sz);
    return (sz == 2'd3) ? '1 : ((64'd1 << (8 << sz)) - 64'd1);
  endfunction

  function automatic logic [63:0] extend_sign(input logic [63:0] v, input logic [1:0] sz);
    int unsigned sh;
    sh = 64 - (8 << sz);
    return 64'($signed(v << sh) >>> sh);
  endfunction

  function automatic logic [63:0] region_limit();
    return (region_size_q > STORE_BYTES) ? 64'(STORE_BYTES) : 64'(region_size_q);
  endfunction

  function automatic logic in_region(input logic [63:0] addr, input logic [1:0] sz);
    logic [63:0] off;
    logic [63:0] lim;
    lim = region_limit();
    if (addr < region_base_q) return 1'b0;
    off = addr - region_base_q;
    return (off <= lim) && ((64'd1 << sz) <= lim - off);
  endfunction

  // Applies one access to the shadow store and returns the word the unit should answer with.
  function automatic out_word_t apply_access(input in_word_t w);
    out_word_t r;
    logic [63:0] mask;
    logic [63:0] a;
    logic [63:0] b;
    logic [63:0] nv;
    logic [15:0] off;
    logic store_it;
    int i;
    r = '0;
    r.hit = in_region(w.address, w.size_log2);
    if (!r.hit || w.command > CMD_CAS) return r;
    mask = size_mask(w.size_log2);
    off = 16'(w.address - region_base_q);
    a = '0;
    for (i = 0; i < (1 << w.size_log2); i++) a[8*i +: 8] = mem_shadow[off + i];
    b = w.operand & mask;
    nv = a;
    store_it = 1'b1;
    r.read_data = a;
    case (w.command)
      CMD_READ: store_it = 1'b0;
      CMD_WRITE: begin
        nv = b;
        r.read_data = '0;
      end
      CMD_SWAP: nv = b;
      CMD_ADD: nv = a + b;
      CMD_AND: nv = a & b;
      CMD_OR: nv = a | b;
      CMD_XOR: nv = a ^ b;
      CMD_MIN: begin
        nv = ($signed(extend_sign(b, w.size_log2)) < $signed(extend_sign(a, w.size_log2))) ?
             b : a;
        r.read_data = extend_sign(a, w.size_log2);
      end
      CMD_MAX: begin
        nv = ($signed(extend_sign(b, w.size_log2)) > $signed(extend_sign(a, w.size_log2))) ?
             b : a;
        r.read_data = extend_sign(a, w.size_log2);
      end
      CMD_MINU: nv = (b < a) ? b : a;
      CMD_MAXU: nv = (b > a) ? b : a;
      default: begin
        r.cas_success = (a == (w.expected & mask));
        store_it = r.cas_success;
        nv = b;
      end
    endcase
    if (store_it) begin
      for (i = 0; i < (1 << w.size_log2); i++) mem_shadow[off + i] = nv[8*i +: 8];
    end
    return r;
  endfunction

  // Queues one request. A request that would read bytes never written becomes a write.
  function automatic void queue_access(input logic [3:0] cmd, input logic [63:0] addr,
                                       input logic [63:0] opnd, input logic [63:0] expd,
                                       input logic [1:0] sz);
    in_word_t w;
    logic [15:0] off;
    logic all_set;
    int i;
    if (in_region(addr, sz) && cmd <= CMD_CAS) begin
      off = 16'(addr - region_base_q);
      all_set = 1'b1;
      for (i = 0; i < (1 << sz); i++) all_set &= byte_written[off + i];
      if (cmd != CMD_WRITE && !all_set) cmd = CMD_WRITE;
      if (cmd == CMD_WRITE) begin
        for (i = 0; i < (1 << sz); i++) byte_written[off + i] = 1'b1;
      end
    end
    w.command = cmd;
    w.address = addr;
    w.operand = opnd;
    w.expected = expd;
    w.size_log2 = sz;
    pending_words = {pending_words, w};
  endfunction

  function automatic logic [63:0] pick_offset(input logic [1:0] sz);
    logic [63:0] lim;
    int unsigned room;
    lim = region_limit();
    if (lim < (64'd1 << sz)) return 64'($urandom_range(0, 3));
    room = 32'(lim - (64'd1 << sz));
    case ($urandom_range(0, 3))
      0, 1: return 64'($urandom_range(0, (room < 63) ? room : 63));
      2: return 64'(room - $urandom_range(0, (room < 15) ? room : 15));
      default: return 64'($urandom_range(0, room));
    endcase
  endfunction

  function automatic logic [63:0] pick_value(input logic [1:0] sz);
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      2: return 64'd1 << ((8 << sz) - 1);
      3: return (64'd1 << ((8 << sz) - 1)) - 64'd1;
      default: return rand64();
    endcase
  endfunction

  // Queues a short run of requests and returns how many it queued. Most runs write a value
  // and then work on it, so that compare-and-swap finds the value it expects.
  function automatic int queue_burst();
    logic [1:0] sz;
    logic [63:0] mask;
    logic [63:0] lim;
    logic [63:0] addr;
    logic [63:0] opnd;
    logic [63:0] expd;
    logic [63:0] known;
    logic [3:0] cmd;
    logic known_ok;
    int n;
    int i;
    sz = 2'($urandom_range(0, 3));
    mask = size_mask(sz);
    lim = region_limit();
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4, 5: begin
        addr = region_base_q + pick_offset(sz);
        known = pick_value(sz) & mask;
        queue_access(CMD_WRITE, addr, known | (rand64() & ~mask), rand64(), sz);
        known_ok = 1'b1;
        n = $urandom_range(1, 4);
        for (i = 0; i < n; i++) begin
          cmd = 4'($urandom_range(CMD_READ, CMD_CAS));
          opnd = pick_value(sz);
          expd = rand64();
          if (cmd == CMD_CAS && known_ok && $urandom_range(0, 3) != 0) begin
            expd = (expd & ~mask) | known;
          end
          queue_access(cmd, addr, opnd, expd, sz);
          if (cmd == CMD_WRITE || cmd == CMD_SWAP) begin
            known = opnd & mask;
          end else if (cmd == CMD_CAS) begin
            if ((expd & mask) == known) known = opnd & mask;
          end else if (cmd != CMD_READ) begin
            known_ok = 1'b0;
          end
        end
        return n + 1;
      end
      6, 7: begin
        queue_access(4'($urandom_range(0, 15)), region_base_q + pick_offset(sz),
                     pick_value(sz), rand64(), sz);
        return 1;
      end
      8: begin
        case ($urandom_range(0, 3))
          0: addr = rand64();
          1: addr = region_base_q - 64'($urandom_range(1, 8));
          2: addr = region_base_q + lim - 64'($urandom_range(0, 7));
          default: addr = region_base_q + lim + 64'($urandom_range(0, 1000));
        endcase
        queue_access(4'($urandom_range(0, 15)), addr, pick_value(sz), rand64(), sz);
        return 1;
      end
      default: begin
        queue_access(4'($urandom_range(CMD_READ, CMD_CAS)),
                     region_base_q + 64'($urandom_range(0, 63)), pick_value(sz), rand64(), sz);
        return 1;
      end
    endcase
  endfunction

  task automatic wait_drained();
    while (pending_words.size() != 0 || in_ch.valid || awaited_results.size() != 0) begin
      @(negedge clk);
    end
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [63:0] value);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_REGION_BASE) begin
      region_base_q = value;
    end else begin
      region_size_q = value[SIZE_W-1:0];
    end
    reg_writes++;
  endtask

  task automatic run_phase(input logic [63:0] base, input logic [SIZE_W-1:0] size,
                           input int count, input int unsigned hold);
    logic [63:0] size_word;
    int made;
    wait_drained();
    size_word = rand64();
    size_word[SIZE_W-1:0] = size;
    write_reg(CFG_REGION_BASE, base);
    write_reg(CFG_REGION_SIZE, size_word);
    @(negedge clk);
    send_steady = (hold > 0) || ($urandom_range(0, 3) == 0);
    recv_steady = ($urandom_range(0, 3) == 0);
    recv_hold = hold;
    made = 0;
    while (made < count) made += queue_burst();
  endtask

  always @(posedge clk) begin : driver
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      send_wait <= 0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        awaited_results = {awaited_results, apply_access(in_ch.data)};
        accepted_words++;
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (send_wait != 0) begin
          send_wait <= send_wait - 1;
          in_ch.valid <= 1'b0;
        end else if (pending_words.size() != 0) begin
          in_ch.data <= pending_words.pop_front();
          in_ch.valid <= 1'b1;
          send_wait <= send_steady ? 0 : $urandom_range(0, 3);
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin : monitor
    out_word_t want;
    int unsigned draw;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      recv_wait <= 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (awaited_results.size() == 0) begin
          errors++;
          if (errors <= MAX_REPORTS) begin
            $display("%0t: unexpected result read_data=%h hit=%b cas_success=%b", $time,
                     out_ch.data.read_data, out_ch.data.hit, out_ch.data.cas_success);
          end
        end else begin
          want = awaited_results.pop_front();
          checked_results++;
          if (want.hit) hit_results++;
          if (want.cas_success) cas_wins++;
          if (out_ch.data.read_data !== want.read_data || out_ch.data.hit !== want.hit ||
              out_ch.data.cas_success !== want.cas_success) begin
            errors++;
            if (errors <= MAX_REPORTS) begin
              $display("%0t: result %0d expected read_data=%h hit=%b cas_success=%b", $time,
                       checked_results, want.read_data, want.hit, want.cas_success);
              $display("%0t: result %0d actual   read_data=%h hit=%b cas_success=%b", $time,
                       checked_results, out_ch.data.read_data, out_ch.data.hit,
                       out_ch.data.cas_success);
            end
          end
        end
      end
      if (recv_hold > 0) begin
        recv_hold <= recv_hold - 1;
        out_ch.ready <= 1'b0;
      end else if (out_ch.valid && out_ch.ready) begin
        draw = recv_steady ? 0 : $urandom_range(0, 3);
        recv_wait <= draw;
        out_ch.ready <= (draw == 0);
      end else if (recv_wait != 0) begin
        recv_wait <= recv_wait - 1;
        out_ch.ready <= (recv_wait == 1);
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin : watchdog
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Timed out after %0d cycles with %0d results outstanding", cycle_count,
               awaited_results.size());
      $display("[memory_region_atomic_unit] ERROR");
      $finish;
    end
  end

  initial begin : stimulus
    int p;
    logic [63:0] base;
    logic [SIZE_W-1:0] size;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    out_ch.ready = 1'b0;
    cycle_count = 0;
    errors = 0;
    recv_hold = 0;
    region_base_q = '0;
    region_size_q = SIZE_W'(STORE_BYTES);
    send_steady = 1'b0;
    recv_steady = 1'b0;
    for (p = 0; p < STORE_BYTES; p++) begin
      mem_shadow[p] = '0;
      byte_written[p] = 1'b0;
    end
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Reset settings: the whole store is the region, based at address zero.
    queue_access(CMD_WRITE, 64'd0, '1, rand64(), 2'd3);
    queue_access(CMD_CAS, 64'd0, 64'd0, '1, 2'd3);
    queue_access(CMD_CAS, 64'd0, 64'd5, '1, 2'd3);
    queue_access(CMD_WRITE, 64'd8, 64'h8000_0000_0000_00FF, rand64(), 2'd3);
    queue_access(CMD_WRITE, 64'd65528, 64'h0123_4567_89AB_CDEF, rand64(), 2'd3);
    queue_access(CMD_READ, 64'd65528, rand64(), rand64(), 2'd3);
    queue_access(CMD_READ, 64'd65535, rand64(), rand64(), 2'd0);
    queue_access(CMD_READ, 64'd65535, rand64(), rand64(), 2'd1);
    queue_access(CMD_READ, 64'd7, rand64(), rand64(), 2'd1);
    queue_access(CMD_ADD, 64'd8, 64'h01, rand64(), 2'd0);
    queue_access(CMD_SWAP, 64'd12, 64'hFFFF_FFFF_7FFF_FFFF, rand64(), 2'd2);
    queue_access(CMD_AND, 64'd8, '1, rand64(), 2'd3);
    queue_access(CMD_OR, 64'd0, 64'h8001, rand64(), 2'd1);
    queue_access(CMD_XOR, 64'd0, '1, rand64(), 2'd2);
    queue_access(CMD_MIN, 64'd15, 64'h80, rand64(), 2'd0);
    queue_access(CMD_MAX, 64'd14, 64'h8000, rand64(), 2'd1);
    queue_access(CMD_MINU, 64'd12, 64'd0, rand64(), 2'd2);
    queue_access(CMD_MAXU, 64'd0, '1, rand64(), 2'd3);
    queue_access(CMD_SPARE_LAST, 64'd0, rand64(), rand64(), 2'd3);
    queue_access(CMD_SPARE_FIRST, '1, rand64(), rand64(), 2'd0);
    queue_access(CMD_READ, '1, rand64(), rand64(), 2'd3);
    queue_access(CMD_WRITE, 64'd65535, 64'd0, rand64(), 2'd0);
    queue_access(CMD_READ, 64'd65535, rand64(), rand64(), 2'd0);

    // An oversized region with the result side held off, so that the unit backs up.
    run_phase(64'd0, '1, 120, 300);
    // Region end beyond the top of the address space, then single-byte and empty regions.
    run_phase(64'hFFFF_FFFF_FFFF_FFF0, SIZE_W'(STORE_BYTES), 80, 0);
    run_phase('1, SIZE_W'(1), 40, 0);
    run_phase(rand64(), '0, 40, 0);
    run_phase(64'($urandom_range(0, 4096)), SIZE_W'(9), 60, 0);
    for (p = 0; p < 5; p++) begin
      base = ($urandom_range(0, 1) == 0) ? rand64() : 64'($urandom_range(0, 4096));
      size = ($urandom_range(0, 2) == 0) ? SIZE_W'($urandom_range(0, (1 << SIZE_W) - 1)) :
             SIZE_W'($urandom_range(64, STORE_BYTES));
      run_phase(base, size, 110, 0);
    end

    wait_drained();
    repeat (8) @(posedge clk);
    $display("Summary: %0d accesses sent over %0d register writes, %0d results checked.",
             accepted_words, reg_writes, checked_results);
    $display("Summary: %0d accesses inside the region, %0d compare-and-swaps stored, %0d faults.",
             hit_results, cas_wins, errors);
    if (errors == 0) begin
      $display("[memory_region_atomic_unit] OK");
    end else begin
      $display("[memory_region_atomic_unit] ERROR");
    end
    $finish;
  end

endmodule

### memory_region_atomic_unit.f
+incdir+src
src/mrau_pkg.sv
src/mrau_in_if.sv
src/mrau_out_if.sv
src/mrau_lane_ram.sv
src/mrau_alu.sv
src/memory_region_atomic_unit.sv
dv/tb_top.sv
